FILE: sv/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// Shared widths, codes, register map and transition functions of the
// door motion state machine.
// ----------------------------------------------------------------------------
package dms_pkg;

	// payload widths
	localparam int ACTION_W = 1;
	localparam int EVENT_W  = 4;
	localparam int STATE_W  = 3;
	localparam int MOTOR_W  = 2;
	localparam int CFG_W    = 16;

	// default width of the tick counters
	localparam int COUNT_WIDTH_DEF = 16;

	// configuration port
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int REG_IDX_LSB = 2;

	localparam logic REG_MOTION = 1'b0;
	localparam logic REG_REPORT = 1'b1;

	localparam logic [CFG_W-1:0] MOTION_RST = CFG_W'(30);
	localparam logic [CFG_W-1:0] REPORT_RST = CFG_W'(10);

	// action codes
	localparam logic ACT_EVENT = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// door states
	localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
	localparam logic [STATE_W-1:0] ST_OPENING   = 3'd1;
	localparam logic [STATE_W-1:0] ST_OPEN      = 3'd2;
	localparam logic [STATE_W-1:0] ST_CLOSING   = 3'd3;
	localparam logic [STATE_W-1:0] ST_CLOSED    = 3'd4;
	localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd5;
	localparam logic [STATE_W-1:0] ST_EMERGENCY = 3'd6;
	localparam logic [STATE_W-1:0] ST_FAULT     = 3'd7;

	// events
	localparam logic [EVENT_W-1:0] EV_OPEN         = 4'd0;
	localparam logic [EVENT_W-1:0] EV_CLOSE        = 4'd1;
	localparam logic [EVENT_W-1:0] EV_STOP         = 4'd2;
	localparam logic [EVENT_W-1:0] EV_EMERG        = 4'd3;
	localparam logic [EVENT_W-1:0] EV_RESET        = 4'd4;
	localparam logic [EVENT_W-1:0] EV_FULL_OPEN    = 4'd5;
	localparam logic [EVENT_W-1:0] EV_FULL_CLOSED  = 4'd6;
	localparam logic [EVENT_W-1:0] EV_OBSTRUCT     = 4'd7;
	localparam logic [EVENT_W-1:0] EV_OBSTRUCT_CLR = 4'd8;
	localparam logic [EVENT_W-1:0] EV_COMM_TO      = 4'd9;
	localparam logic [EVENT_W-1:0] EV_SENSOR_FLT   = 4'd10;
	localparam logic [EVENT_W-1:0] EV_SYSTEM_FLT   = 4'd11;

	// motor drive
	localparam logic [MOTOR_W-1:0] MOT_STOP  = 2'd0;
	localparam logic [MOTOR_W-1:0] MOT_OPEN  = 2'd1;
	localparam logic [MOTOR_W-1:0] MOT_CLOSE = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] motion_ticks;
		logic [CFG_W-1:0] report_interval_ticks;
	} cfg_t;

	// event transition table; unlisted pairs keep the state
	function automatic logic [STATE_W-1:0] next_state(
		input logic [STATE_W-1:0] cur,
		input logic [EVENT_W-1:0] ev
	);
		logic [STATE_W-1:0] ns;
		ns = cur;
		if (ev == EV_EMERG) begin
			ns = ST_EMERGENCY;
		end else if (ev == EV_RESET) begin
			ns = ST_IDLE;
		end else if (ev == EV_SENSOR_FLT || ev == EV_SYSTEM_FLT) begin
			if (cur != ST_EMERGENCY) ns = ST_FAULT;
		end else begin
			unique case (cur)
				ST_IDLE: begin
					if (ev == EV_OPEN) ns = ST_OPENING;
					else if (ev == EV_COMM_TO) ns = ST_FAULT;
				end
				ST_OPENING: begin
					if (ev == EV_CLOSE) ns = ST_CLOSING;
					else if (ev == EV_STOP) ns = ST_STOPPED;
					else if (ev == EV_FULL_OPEN) ns = ST_OPEN;
				end
				ST_OPEN: begin
					if (ev == EV_CLOSE) ns = ST_CLOSING;
					else if (ev == EV_COMM_TO) ns = ST_FAULT;
				end
				ST_CLOSING: begin
					if (ev == EV_OPEN || ev == EV_OBSTRUCT) ns = ST_OPENING;
					else if (ev == EV_STOP) ns = ST_STOPPED;
					else if (ev == EV_FULL_CLOSED) ns = ST_CLOSED;
					else if (ev == EV_COMM_TO) ns = ST_FAULT;
				end
				ST_CLOSED: begin
					if (ev == EV_OPEN) ns = ST_OPENING;
					else if (ev == EV_COMM_TO) ns = ST_FAULT;
				end
				ST_STOPPED: begin
					if (ev == EV_OPEN) ns = ST_OPENING;
					else if (ev == EV_CLOSE) ns = ST_CLOSING;
					else if (ev == EV_COMM_TO) ns = ST_FAULT;
				end
				default: begin
					ns = cur;
				end
			endcase
		end
		return ns;
	endfunction

	function automatic logic [MOTOR_W-1:0] motor_of(input logic [STATE_W-1:0] s);
		logic [MOTOR_W-1:0] m;
		m = MOT_STOP;
		if (s == ST_OPENING || s == ST_EMERGENCY) m = MOT_OPEN;
		else if (s == ST_CLOSING) m = MOT_CLOSE;
		return m;
	endfunction

endpackage

FILE: sv/dms_if.sv
// ----------------------------------------------------------------------------
// dms_if
// Valid/ready channels of the door motion state machine: event and tick
// items in, status items out.
// ----------------------------------------------------------------------------
interface dms_in_if;
	logic                         valid;
	logic                         ready;
	logic [dms_pkg::ACTION_W-1:0] action;
	logic [dms_pkg::EVENT_W-1:0]  event_code;

	modport source (output valid, output action, output event_code, input ready);
	modport sink   (input valid, input action, input event_code, output ready);
endinterface

interface dms_out_if;
	logic                        valid;
	logic                        ready;
	logic [dms_pkg::STATE_W-1:0] door_state;
	logic [dms_pkg::MOTOR_W-1:0] motor_drive;
	logic                        state_entered;
	logic                        periodic_report;

	modport source (
		output valid, output door_state, output motor_drive,
		output state_entered, output periodic_report, input ready
	);
	modport sink (
		input valid, input door_state, input motor_drive,
		input state_entered, input periodic_report, output ready
	);
endinterface

FILE: sv/dms_cfg.sv
// ----------------------------------------------------------------------------
// dms_cfg
// APB register file: motion time and report interval.
// ----------------------------------------------------------------------------
module dms_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dms_pkg::APB_AW-1:0]  paddr,
	input  logic [dms_pkg::APB_DW-1:0]  pwdata,
	output logic [dms_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output dms_pkg::cfg_t               cfg
);
	import dms_pkg::*;

	logic [CFG_W-1:0] motion_q;
	logic [CFG_W-1:0] report_q;
	logic             wr_en;
	logic             reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	// one word per register, low address bits ignored
	assign reg_idx = paddr[REG_IDX_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= MOTION_RST;
			report_q <= REPORT_RST;
		end else if (wr_en) begin
			if (reg_idx == REG_MOTION) motion_q <= pwdata[CFG_W-1:0];
			else if (reg_idx == REG_REPORT) report_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MOTION) prdata = APB_DW'(motion_q);
		else prdata = APB_DW'(report_q);
	end

	assign cfg.motion_ticks          = motion_q;
	assign cfg.report_interval_ticks = report_q;

endmodule

FILE: sv/door_motion_state_machine_core.sv
// ----------------------------------------------------------------------------
// door_motion_state_machine_core
// Eight-state door controller driven by event and tick items.
// ----------------------------------------------------------------------------
// Takes one item per clock, unless the result register stalls, and returns
// exactly one status item for each, in order. An accepted item lands in an
// input register, the next state and both tick counters are worked out in
// one short pass from that register and the controller state, and the
// status goes to a result register. A stalled result register holds the
// input register, and req.ready then follows rsp.ready in the same cycle.
// The user must write motion time and report interval over the APB port at
// byte addresses 0 and 4 only while no item is in flight (not enforced).
module door_motion_state_machine_core #(
	parameter int COUNT_WIDTH = dms_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dms_in_if.sink                      req,
	dms_out_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dms_pkg::APB_AW-1:0]  paddr,
	input  logic [dms_pkg::APB_DW-1:0]  pwdata,
	output logic [dms_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import dms_pkg::*;

	// counters and motion/report settings are compared at the wider width
	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	cfg_t cfg;

	// input register
	logic                 valid_s1;
	logic [ACTION_W-1:0]  action_s1;
	logic [EVENT_W-1:0]   event_s1;

	// controller state
	logic [STATE_W-1:0]     state_q;
	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic [COUNT_WIDTH-1:0] report_cnt_q;

	// result register
	logic               out_valid_q;
	logic [STATE_W-1:0] out_state_q;
	logic [MOTOR_W-1:0] out_motor_q;
	logic               out_entered_q;
	logic               out_report_q;

	// next-state pass
	logic                   advance;
	logic                   is_tick;
	logic [COUNT_WIDTH-1:0] elapsed_inc;
	logic [COUNT_WIDTH-1:0] report_inc;
	logic                   motion_done;
	logic                   report_due;
	logic [STATE_W-1:0]     ns;
	logic                   entered;
	logic [COUNT_WIDTH-1:0] elapsed_nx;
	logic [COUNT_WIDTH-1:0] report_nx;

	dms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held item moves on when the result register is free or draining
	assign advance   = valid_s1 & (~out_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			event_s1  <= req.event_code;
		end
	end

	assign is_tick = (action_s1 == ACT_TICK);

	// saturating increments
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + COUNT_WIDTH'(1);
	assign report_inc  = (&report_cnt_q) ? report_cnt_q : report_cnt_q + COUNT_WIDTH'(1);

	// a zero setting behaves as one since the incremented count is never zero
	assign motion_done = CMP_W'(elapsed_inc) >= CMP_W'(cfg.motion_ticks);
	assign report_due  = CMP_W'(report_inc) >= CMP_W'(cfg.report_interval_ticks);

	always_comb begin
		ns = state_q;
		if (!is_tick) begin
			ns = next_state(state_q, event_s1);
		end else if (motion_done) begin
			if (state_q == ST_OPENING) ns = ST_OPEN;
			else if (state_q == ST_CLOSING) ns = ST_CLOSED;
		end
	end

	assign entered = (ns != state_q);

	// entry clears the motion count after the tick increment
	always_comb begin
		elapsed_nx = elapsed_q;
		report_nx  = report_cnt_q;
		if (is_tick) begin
			elapsed_nx = elapsed_inc;
			report_nx  = report_due ? '0 : report_inc;
		end
		if (entered) elapsed_nx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			report_cnt_q <= '0;
		end else if (advance) begin
			state_q      <= ns;
			elapsed_q    <= elapsed_nx;
			report_cnt_q <= report_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q   <= ns;
			out_motor_q   <= motor_of(ns);
			out_entered_q <= entered;
			out_report_q  <= is_tick & report_due;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.door_state      = out_state_q;
	assign rsp.motor_drive     = out_motor_q;
	assign rsp.state_entered   = out_entered_q;
	assign rsp.periodic_report = out_report_q;

endmodule

FILE: sv/dms_checker.sv
// ----------------------------------------------------------------------------
// dms_checker
// Port-level checks of the door motion state machine, bound to the core.
// ----------------------------------------------------------------------------
module dms_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [dms_pkg::STATE_W-1:0] rsp_door_state,
	input logic [dms_pkg::MOTOR_W-1:0] rsp_motor_drive,
	input logic                        rsp_state_entered,
	input logic                        rsp_periodic_report
);
	import dms_pkg::*;

	// door state of the last delivered item
	logic [STATE_W-1:0] last_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= ST_IDLE;
		end else if (rsp_valid && rsp_ready) begin
			last_state_q <= rsp_door_state;
		end
	end

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_door_state)
			&& $stable(rsp_motor_drive) && $stable(rsp_state_entered)
			&& $stable(rsp_periodic_report))
		else $error("result changed while stalled");

	// motor follows the reported state
	a_motor_map: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_motor_drive ==
			(((rsp_door_state == ST_OPENING) || (rsp_door_state == ST_EMERGENCY)) ? MOT_OPEN :
			((rsp_door_state == ST_CLOSING) ? MOT_CLOSE : MOT_STOP)))
		else $error("motor drive does not match door state");

	// entry flag marks exactly a change from the previous result
	a_entry_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_state_entered == (rsp_door_state != last_state_q))
		else $error("entry flag disagrees with state sequence");

	// a cycle spent in reset leaves nothing offered
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("result offered after reset");

endmodule

bind door_motion_state_machine_core dms_checker u_dms_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_door_state      (rsp.door_state),
	.rsp_motor_drive     (rsp.motor_drive),
	.rsp_state_entered   (rsp.state_entered),
	.rsp_periodic_report (rsp.periodic_report)
);

FILE: tb/sv/door_motion_state_machine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// door_motion_state_machine_core_tb
// Self-checking bench for the door controller core: a directed table of
// events and ticks under the reset settings, then random phases. The random
// phases are mostly ticks, with state-aware commands and noise codes
// mixed in. Each phase has its own motion time and report interval,
// and in most the sender and receiver idle at random. Every status item is
// checked against its table row or a local model of the controller.
// ----------------------------------------------------------------------------
module door_motion_state_machine_core_tb;
	import dms_pkg::*;

	localparam int CW          = COUNT_WIDTH_DEF;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 150;
	localparam int LIMIT       = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int DIR_ROWS    = 24;

	// event codes the controller has no meaning for
	localparam logic [EVENT_W-1:0] EV_UNKNOWN_LO = 4'd12;
	localparam logic [EVENT_W-1:0] EV_UNKNOWN_HI = 4'd15;

	// one status item as the core returns it
	typedef struct packed {
		logic [STATE_W-1:0] door_state;
		logic [MOTOR_W-1:0] motor_drive;
		logic               state_entered;
		logic               periodic_report;
	} status_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		logic               act;
		logic [EVENT_W-1:0] code;
		logic [7:0]         reps;
		logic               typed;
		status_t            want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	// configuration port
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	dms_in_if  req_if ();
	dms_out_if rsp_if ();

	door_motion_state_machine_core #(
		.COUNT_WIDTH(CW)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #5 clk = ~clk;

	// local copy of the controller and its settings
	logic [STATE_W-1:0] door_st;
	logic [CW-1:0]      elapsed_cnt;
	logic [CW-1:0]      report_cnt;
	logic [CFG_W-1:0]   cfg_motion;
	logic [CFG_W-1:0]   cfg_report;

	// status items still owed by the core, oldest first
	status_t pending_status [$];

	int  mismatch_cnt = 0;
	int  cycle_cnt = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;

	// receiver hold-off: requested by the stimulus, counted by the receiver
	bit  hold_req = 1'b0;
	bit  hold_taken = 1'b0;
	int  hold_left = 0;

	// directed table, run under the reset settings (motion 30, report 10)
	stim_row_t directed_rows [DIR_ROWS] = '{
		// stop means nothing in idle
		'{ACT_EVENT, EV_STOP,         8'd1, 1'b1, '{ST_IDLE,      MOT_STOP,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_OPEN,         8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b1, 1'b0}},
		// re-entering the current state is no change
		'{ACT_EVENT, EV_OPEN,         8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b0, 1'b0}},
		// unknown codes are ignored
		'{ACT_EVENT, EV_UNKNOWN_HI,   8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_UNKNOWN_LO,   8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_FULL_OPEN,    8'd1, 1'b1, '{ST_OPEN,      MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_CLOSE,        8'd1, 1'b1, '{ST_CLOSING,   MOT_CLOSE, 1'b1, 1'b0}},
		'{ACT_EVENT, EV_OBSTRUCT,     8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_STOP,         8'd1, 1'b1, '{ST_STOPPED,   MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_CLOSE,        8'd1, 1'b1, '{ST_CLOSING,   MOT_CLOSE, 1'b1, 1'b0}},
		'{ACT_EVENT, EV_FULL_CLOSED,  8'd1, 1'b1, '{ST_CLOSED,    MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_COMM_TO,      8'd1, 1'b1, '{ST_FAULT,     MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_OPEN,         8'd1, 1'b1, '{ST_FAULT,     MOT_STOP,  1'b0, 1'b0}},
		// emergency overrides, faults do not leave emergency
		'{ACT_EVENT, EV_EMERG,        8'd1, 1'b1, '{ST_EMERGENCY, MOT_OPEN,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_SENSOR_FLT,   8'd1, 1'b1, '{ST_EMERGENCY, MOT_OPEN,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_EMERG,        8'd1, 1'b1, '{ST_EMERGENCY, MOT_OPEN,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_RESET,        8'd1, 1'b1, '{ST_IDLE,      MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_SYSTEM_FLT,   8'd1, 1'b1, '{ST_FAULT,     MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_RESET,        8'd1, 1'b1, '{ST_IDLE,      MOT_STOP,  1'b1, 1'b0}},
		'{ACT_EVENT, EV_OBSTRUCT_CLR, 8'd1, 1'b1, '{ST_IDLE,      MOT_STOP,  1'b0, 1'b0}},
		'{ACT_EVENT, EV_OPEN,         8'd1, 1'b1, '{ST_OPENING,   MOT_OPEN,  1'b1, 1'b0}},
		// ticks through the first report at the reset interval
		'{ACT_TICK,  EV_UNKNOWN_HI,   8'd12, 1'b0, '0},
		'{ACT_EVENT, EV_CLOSE,        8'd1, 1'b1, '{ST_CLOSING,   MOT_CLOSE, 1'b1, 1'b0}},
		// ticks past the reset motion time, closing completes
		'{ACT_TICK,  EV_OPEN,         8'd35, 1'b0, '0}
	};

	// motor drive that goes with a door state
	function automatic logic [MOTOR_W-1:0] drive_for(input logic [STATE_W-1:0] st);
		logic [MOTOR_W-1:0] drv;
		drv = MOT_STOP;
		if (st == ST_OPENING || st == ST_EMERGENCY) drv = MOT_OPEN;
		else if (st == ST_CLOSING) drv = MOT_CLOSE;
		return drv;
	endfunction

	// door state after one event, before the entry rule
	function automatic logic [STATE_W-1:0] door_after_event(
		input logic [STATE_W-1:0] cur,
		input logic [EVENT_W-1:0] ev
	);
		logic [STATE_W-1:0] nxt;
		nxt = cur;
		case (ev)
			EV_EMERG: nxt = ST_EMERGENCY;
			EV_RESET: nxt = ST_IDLE;
			EV_SENSOR_FLT, EV_SYSTEM_FLT: begin
				if (cur != ST_EMERGENCY) nxt = ST_FAULT;
			end
			EV_COMM_TO: begin
				if (cur inside {ST_IDLE, ST_OPEN, ST_CLOSING, ST_CLOSED, ST_STOPPED})
					nxt = ST_FAULT;
			end
			EV_OPEN: begin
				if (cur inside {ST_IDLE, ST_CLOSING, ST_CLOSED, ST_STOPPED}) nxt = ST_OPENING;
			end
			EV_OBSTRUCT: begin
				if (cur == ST_CLOSING) nxt = ST_OPENING;
			end
			EV_CLOSE: begin
				if (cur inside {ST_OPENING, ST_OPEN, ST_STOPPED}) nxt = ST_CLOSING;
			end
			EV_STOP: begin
				if (cur inside {ST_OPENING, ST_CLOSING}) nxt = ST_STOPPED;
			end
			EV_FULL_OPEN: begin
				if (cur == ST_OPENING) nxt = ST_OPEN;
			end
			EV_FULL_CLOSED: begin
				if (cur == ST_CLOSING) nxt = ST_CLOSED;
			end
			default: begin
				nxt = cur;
			end
		endcase
		return nxt;
	endfunction

	// advance the local controller by one accepted item
	task automatic predict_status(
		input  logic               act,
		input  logic [EVENT_W-1:0] code,
		output status_t            exp
	);
		logic [STATE_W-1:0] nxt;
		logic               entered;
		logic               report;
		entered = 1'b0;
		report = 1'b0;
		nxt = door_st;
		if (act == ACT_EVENT) begin
			nxt = door_after_event(door_st, code);
		end else begin
			// both counters saturate, then compare
			if (elapsed_cnt != '1) elapsed_cnt = elapsed_cnt + 1'b1;
			if (report_cnt != '1) report_cnt = report_cnt + 1'b1;
			if (elapsed_cnt >= CW'(cfg_motion)) begin
				if (door_st == ST_OPENING) nxt = ST_OPEN;
				else if (door_st == ST_CLOSING) nxt = ST_CLOSED;
			end
			if (report_cnt >= CW'(cfg_report)) begin
				report = 1'b1;
				report_cnt = '0;
			end
		end
		// only a real change counts as an entry and clears elapsed time
		if (nxt != door_st) begin
			door_st = nxt;
			elapsed_cnt = '0;
			entered = 1'b1;
		end
		exp = '{door_st, drive_for(door_st), entered, report};
	endtask

	// offer one item, wait for acceptance, log its status, then maybe idle
	task automatic send_item(
		input logic               act,
		input logic [EVENT_W-1:0] code,
		input logic               typed,
		input status_t            want
	);
		status_t exp;
		req_if.valid      <= 1'b1;
		req_if.action     <= act;
		req_if.event_code <= code;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		predict_status(act, code, exp);
		pending_status.push_back(typed ? want : exp);
		// sender gaps, geometric in length
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// two-phase register write; upper data bits carry junk
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx) << REG_IDX_LSB;
		pwdata  <= {16'($urandom_range(0, 65535)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// written at this edge
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_MOTION) cfg_motion = value;
		else cfg_report = value;
	endtask

	// receiver: random ready, plus one long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// status checker against the oldest expectation
	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			got = '{rsp_if.door_state, rsp_if.motor_drive,
				rsp_if.state_entered, rsp_if.periodic_report};
			if (pending_status.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected status item: state %0d motor %0d entered %0b report %0b",
						$realtime, got.door_state, got.motor_drive,
						got.state_entered, got.periodic_report);
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$write("%0t: mismatch: expected state %0d motor %0d entered %0b report %0b",
							$realtime, want.door_state, want.motor_drive,
							want.state_entered, want.periodic_report);
						$display(", got state %0d motor %0d entered %0b report %0b",
							got.door_state, got.motor_drive,
							got.state_entered, got.periodic_report);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic               act;
		logic [EVENT_W-1:0] code;
		logic [CFG_W-1:0]   mt;
		logic [CFG_W-1:0]   ri;
		int                 roll;

		// known values on every input from time zero
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_if.valid      = 1'b0;
		req_if.action     = ACT_EVENT;
		req_if.event_code = EV_OPEN;
		rsp_if.ready      = 1'b0;

		// local model starts from the reset state
		door_st     = ST_IDLE;
		elapsed_cnt = '0;
		report_cnt  = '0;
		cfg_motion  = MOTION_RST;
		cfg_report  = REPORT_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings
		src_idle_pct = 30;
		snk_idle_pct = 71;
		foreach (directed_rows[r]) begin
			repeat (directed_rows[r].reps)
				send_item(directed_rows[r].act, directed_rows[r].code,
					directed_rows[r].typed, directed_rows[r].want);
		end
		req_if.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);

		// random phases, each with its own settings and idle pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// lowest legal settings
					mt = 16'd1;
					ri = 16'd1;
				end
				1: begin
					// highest settings, motion only ends by sensor events
					mt = 16'hFFFF;
					ri = 16'hFFFF;
				end
				2: begin
					// zero behaves as one for both
					mt = 16'd0;
					ri = 16'd0;
				end
				default: begin
					mt = 16'($urandom_range(1, 12));
					ri = 16'($urandom_range(1, 15));
				end
			endcase

			// sender 30 / receiver 71, then swapped, then no idling
			src_idle_pct = (ph < 3) ? 30 : (ph < 5) ? 71 : 0;
			snk_idle_pct = (ph < 3) ? 71 : (ph < 5) ? 30 : 0;
			hold_req = (ph == 5);

			write_reg(REG_MOTION, mt);
			write_reg(REG_REPORT, ri);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(99);
				code = EVENT_W'($urandom_range(15));
				if (roll < 55) begin
					act = ACT_TICK;
				end else begin
					act = ACT_EVENT;
					// mostly commands that move the door, noise otherwise
					if (roll < 88) begin
						if (door_st == ST_EMERGENCY || door_st == ST_FAULT) begin
							code = ($urandom_range(3) == 0) ? EV_SENSOR_FLT : EV_RESET;
						end else begin
							case ($urandom_range(5))
								0: code = EV_OPEN;
								1: code = EV_CLOSE;
								2: code = EV_STOP;
								3: code = EV_FULL_OPEN;
								4: code = EV_FULL_CLOSED;
								default: code = EV_OBSTRUCT;
							endcase
						end
					end
				end
				send_item(act, code, 1'b0, '0);
			end

			// drain before the next settings go in
			req_if.valid <= 1'b0;
			while (pending_status.size() != 0) @(posedge clk);
		end

		// wait for any stray status item
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
